// ----- rtl/prs_pwl_pkg.sv -----
// Shared types and constants for the pulse rate to wind speed converter.
package prs_pwl_pkg;

    localparam int RATE_W     = 16;
    localparam int SPEED_W    = 16;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS_0_1  = 3'd1;

    localparam logic [CNT_W-1:0]      RESET_POINT_COUNT = 4'd2;
    localparam logic [CFG_DATA_W-1:0] RESET_POINTS_0_1  = 64'h0042_02C0_0000_0000;

    // 3/128 Hz (about 0.023 Hz) in Q9.7
    localparam logic [RATE_W-1:0] LOW_CUT_RAW = 16'd3;

    // divider geometry: 32-bit magnitude over 16-bit magnitude
    localparam int NUM_W               = 32;
    localparam int DEN_W               = 16;
    localparam int DIV_BITS_PER_STAGE  = 4;
    localparam int DIV_STAGES          = NUM_W / DIV_BITS_PER_STAGE;

    // travels beside the quotient through the divider
    typedef struct packed {
        logic [SPEED_W-1:0] base;
        logic               neg;
    } t_div_side;

endpackage

// ----- rtl/prs_pwl_div.sv -----
// Pipelined restoring divider, unsigned 32 by 16, four quotient bits per stage.
module prs_pwl_div (
    input  logic                                  i_clk,
    input  logic [prs_pwl_pkg::DIV_STAGES-1:0]    i_en,
    input  logic [prs_pwl_pkg::NUM_W-1:0]         i_num,
    input  logic [prs_pwl_pkg::DEN_W-1:0]         i_den,
    input  prs_pwl_pkg::t_div_side                i_side,
    output logic [prs_pwl_pkg::NUM_W-1:0]         o_quo,
    output prs_pwl_pkg::t_div_side                o_side
);
    import prs_pwl_pkg::*;

    logic [DEN_W-1:0] r_rem  [DIV_STAGES];
    logic [NUM_W-1:0] r_nq   [DIV_STAGES];
    logic [DEN_W-1:0] r_den  [DIV_STAGES];
    t_div_side        r_side [DIV_STAGES];

    logic [DEN_W-1:0] pre_rem  [DIV_STAGES];
    logic [NUM_W-1:0] pre_nq   [DIV_STAGES];
    logic [DEN_W-1:0] pre_den  [DIV_STAGES];
    t_div_side        pre_side [DIV_STAGES];
    logic [DEN_W-1:0] n_rem    [DIV_STAGES];
    logic [NUM_W-1:0] n_nq     [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stg
        if (k == 0) begin : g_first
            assign pre_rem[k]  = '0;
            assign pre_nq[k]   = i_num;
            assign pre_den[k]  = i_den;
            assign pre_side[k] = i_side;
        end else begin : g_rest
            assign pre_rem[k]  = r_rem[k-1];
            assign pre_nq[k]   = r_nq[k-1];
            assign pre_den[k]  = r_den[k-1];
            assign pre_side[k] = r_side[k-1];
        end

        // nq shifts the dividend out at the top and the quotient in at the bottom
        always_comb begin
            logic [DEN_W:0]   t;
            logic [DEN_W-1:0] rem;
            logic [NUM_W-1:0] nq;
            rem = pre_rem[k];
            nq  = pre_nq[k];
            for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
                t  = {rem, nq[NUM_W-1]};
                nq = {nq[NUM_W-2:0], 1'b0};
                if (t >= {1'b0, pre_den[k]}) begin
                    t     = t - {1'b0, pre_den[k]};
                    nq[0] = 1'b1;
                end
                rem = t[DEN_W-1:0];
            end
            n_rem[k] = rem;
            n_nq[k]  = nq;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k]  <= n_rem[k];
                r_nq[k]   <= n_nq[k];
                r_den[k]  <= pre_den[k];
                r_side[k] <= pre_side[k];
            end
        end
    end

    assign o_quo  = r_nq[DIV_STAGES-1];
    assign o_side = r_side[DIV_STAGES-1];

endmodule

// ----- rtl/pulse_rate_to_speed_pwl.sv -----
// Top level: anemometer pulse rate to wind speed by piecewise linear lookup.
//
// Input stream s_axis carries one pulse rate (unsigned Q9.7 Hz) per item in
// tdata[15:0]. Output stream m_axis returns one wind speed (unsigned Q9.7 m/s)
// per item in tdata[15:0], with tuser[0] set when the value was clamped.
// Breakpoints and the point count are written on the i_cfg_* port while no
// item is in flight; a write takes effect at the next clock edge.
//
// One item is accepted every cycle while m_axis does not stall. The depth
// comes from the 32-bit quotient, which is resolved 4 bits per stage in an
// 8-stage divider; the other stages compare, select the segment, form
// differences, multiply and finally add and clamp.
//
// Reset empties the pipeline and loads the default table: two points,
// (0,0) and (5.5 Hz, 0.5156 m/s). When m_axis stalls, occupied stages hold
// their items while empty stages ahead of them keep filling; s_axis_tready
// drops only once every stage holds an item and the output is still stalled.
module pulse_rate_to_speed_pwl #(
    parameter int MAX_POINTS = 10
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [prs_pwl_pkg::RATE_W-1:0]        s_axis_tdata,   // [15:0] pulse_rate
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [prs_pwl_pkg::SPEED_W-1:0]       m_axis_tdata,   // [15:0] wind_speed
    output logic                                  m_axis_tuser,   // [0] clamped
    input  logic                                  i_cfg_we,
    input  logic [prs_pwl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [prs_pwl_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import prs_pwl_pkg::*;

    localparam int NREG = (MAX_POINTS + 1) / 2;
    localparam int SEGW = $clog2(MAX_POINTS);
    localparam int NSTG = DIV_STAGES + 5;
    localparam int DIV0 = 4;

    // ---------------- configuration ----------------
    logic [CNT_W-1:0]      r_point_count;
    logic [CFG_DATA_W-1:0] r_points [NREG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= RESET_POINT_COUNT;
            for (int k = 0; k < NREG; k++) begin
                r_points[k] <= (k == 0) ? RESET_POINTS_0_1 : '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_POINT_COUNT) begin
                r_point_count <= i_cfg_wdata[CNT_W-1:0];
            end
            for (int k = 0; k < NREG; k++) begin
                if (i_cfg_idx == REG_POINTS_0_1 + CFG_IDX_W'(k)) begin
                    r_points[k] <= i_cfg_wdata;
                end
            end
        end
    end

    // point i and the one before it (the origin ahead of point 0)
    logic [RATE_W-1:0]  pt_x [MAX_POINTS];
    logic [SPEED_W-1:0] pt_y [MAX_POINTS];
    logic [RATE_W-1:0]  pv_x [MAX_POINTS];
    logic [SPEED_W-1:0] pv_y [MAX_POINTS];

    always_comb begin
        for (int i = 0; i < MAX_POINTS; i++) begin
            pt_x[i] = r_points[i/2][(i%2)*32 +: RATE_W];
            pt_y[i] = r_points[i/2][(i%2)*32 + 16 +: SPEED_W];
        end
        pv_x[0] = '0;
        pv_y[0] = '0;
        for (int i = 1; i < MAX_POINTS; i++) begin
            pv_x[i] = pt_x[i-1];
            pv_y[i] = pt_y[i-1];
        end
    end

    logic [CNT_W-1:0] n_used;

    always_comb begin
        if (r_point_count < 4'd2) begin
            n_used = 4'd2;
        end else if (r_point_count > CNT_W'(MAX_POINTS)) begin
            n_used = CNT_W'(MAX_POINTS);
        end else begin
            n_used = r_point_count;
        end
    end

    // ---------------- stage flow ----------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] stg_en;

    always_comb begin
        stg_en[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = stg_en[0];

    // ---------------- stage 1: compare against every x ----------------
    logic [RATE_W-1:0]     r_s1_rate;
    logic [MAX_POINTS-1:0] r_s1_lt;
    logic                  r_s1_low;
    logic [MAX_POINTS-1:0] n_s1_lt;

    always_comb begin
        for (int i = 0; i < MAX_POINTS; i++) begin
            n_s1_lt[i] = s_axis_tdata < pt_x[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_s1_rate <= s_axis_tdata;
            r_s1_lt   <= n_s1_lt;
            r_s1_low  <= s_axis_tdata <= LOW_CUT_RAW;
        end
    end

    // ---------------- stage 2: pick the segment ----------------
    logic [RATE_W-1:0] r_s2_rate;
    logic [SEGW-1:0]   r_s2_seg;
    logic              r_s2_low;
    logic [SEGW-1:0]   n_s2_seg;

    // segment 0 runs from the origin to point 0; past the table use the last one
    always_comb begin
        n_s2_seg = SEGW'(n_used - 4'd1);
        for (int i = MAX_POINTS - 1; i >= 1; i--) begin
            if (r_s1_lt[i] && (CNT_W'(i) < n_used)) begin
                n_s2_seg = SEGW'(i);
            end
        end
        if (r_s1_lt[0]) begin
            n_s2_seg = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_s2_rate <= r_s1_rate;
            r_s2_seg  <= n_s2_seg;
            r_s2_low  <= r_s1_low;
        end
    end

    // ---------------- stage 3: endpoints and differences ----------------
    logic [RATE_W-1:0]         r_s3_a;
    logic signed [SPEED_W:0]   r_s3_dy;
    logic signed [RATE_W:0]    r_s3_den;
    logic [SPEED_W-1:0]        r_s3_base;
    logic                      r_s3_zq;
    logic [RATE_W-1:0]         s3_xa, s3_xb;
    logic [SPEED_W-1:0]        s3_ya, s3_yb;
    logic                      s3_flat;

    always_comb begin
        s3_xa   = pv_x[r_s2_seg];
        s3_xb   = pt_x[r_s2_seg];
        s3_ya   = pv_y[r_s2_seg];
        s3_yb   = pt_y[r_s2_seg];
        s3_flat = s3_xa == s3_xb;
    end

    // a flat segment gives its end y with no quotient; a rate at or below the low cut gives zero
    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r_s3_a    <= r_s2_rate - s3_xa;
            r_s3_dy   <= $signed({1'b0, s3_yb}) - $signed({1'b0, s3_ya});
            r_s3_den  <= $signed({1'b0, s3_xb}) - $signed({1'b0, s3_xa});
            r_s3_zq   <= r_s2_low || s3_flat;
            r_s3_base <= r_s2_low ? '0 : (s3_flat ? s3_yb : s3_ya);
        end
    end

    // ---------------- stage 4: magnitudes and product ----------------
    logic [NUM_W-1:0]   r_s4_num;
    logic [DEN_W-1:0]   r_s4_dmag;
    t_div_side          r_s4_side;
    logic [SPEED_W-1:0] s4_dymag;
    logic [DEN_W-1:0]   s4_denmag;
    logic [NUM_W-1:0]   s4_prod;

    always_comb begin
        s4_dymag  = r_s3_dy[SPEED_W] ? SPEED_W'(-r_s3_dy) : r_s3_dy[SPEED_W-1:0];
        s4_denmag = r_s3_den[RATE_W] ? DEN_W'(-r_s3_den) : r_s3_den[DEN_W-1:0];
        s4_prod   = r_s3_a * s4_dymag;
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r_s4_num       <= r_s3_zq ? '0 : s4_prod;
            r_s4_dmag      <= r_s3_zq ? DEN_W'(1) : s4_denmag;
            r_s4_side.base <= r_s3_base;
            r_s4_side.neg  <= r_s3_dy[SPEED_W] ^ r_s3_den[RATE_W];
        end
    end

    // ---------------- divider ----------------
    logic [NUM_W-1:0] div_quo;
    t_div_side        div_side;

    prs_pwl_div u_div (
        .i_clk  (i_clk),
        .i_en   (stg_en[DIV0 +: DIV_STAGES]),
        .i_num  (r_s4_num),
        .i_den  (r_s4_dmag),
        .i_side (r_s4_side),
        .o_quo  (div_quo),
        .o_side (div_side)
    );

    // ---------------- output stage: sign, add, clamp ----------------
    logic [SPEED_W-1:0]      r_out_speed;
    logic                    r_out_sat;
    logic signed [NUM_W+1:0] fin_q;
    logic signed [NUM_W+1:0] fin_v;
    logic [SPEED_W-1:0]      fin_speed;
    logic                    fin_sat;

    always_comb begin
        fin_q = $signed({2'b00, div_quo});
        if (div_side.neg) begin
            fin_q = -fin_q;
        end
        fin_v = $signed({{(NUM_W + 2 - SPEED_W){1'b0}}, div_side.base}) + fin_q;
        if (fin_v[NUM_W+1]) begin
            fin_speed = '0;
            fin_sat   = 1'b1;
        end else if (fin_v[NUM_W:SPEED_W] != '0) begin
            fin_speed = '1;
            fin_sat   = 1'b1;
        end else begin
            fin_speed = fin_v[SPEED_W-1:0];
            fin_sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[NSTG-1]) begin
            r_out_speed <= fin_speed;
            r_out_sat   <= fin_sat;
        end
    end

    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = r_out_speed;
    assign m_axis_tuser  = r_out_sat;

    // ---------------- assertions ----------------
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while the pipeline could advance");

    a_clamp_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0 || m_axis_tdata == '1))
        else $error("clamp flag set on an unclamped speed");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r_s4_dmag != '0))
        else $error("zero divisor entered the divider");

endmodule
